FILE: hdl/ugbb_pkg.sv
// Shared constants and codes for the uniform grid broad-phase binning block.
package ugbb_pkg;

    // Default grid geometry
    localparam int GRID_COLS_DEF      = 64;
    localparam int GRID_ROWS_DEF      = 64;
    localparam int CELL_SIZE_DEF      = 32;
    localparam int SLOTS_PER_CELL_DEF = 8;

    // Fixed field widths
    localparam int OP_W     = 2;
    localparam int ID_W     = 16;
    localparam int COORD_W  = 16;
    localparam int CIDX_W   = 6;
    localparam int STATUS_W = 2;

    // Register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [COORD_W-1:0] ORIGIN_RESET = 16'hFC00;
    localparam logic REG_ORIGIN_X = 1'b0;
    localparam logic REG_ORIGIN_Y = 1'b1;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_CELL = 2'd3;

endpackage

FILE: hdl/ugbb_req_if.sv
// Request channel: valid/ready handshake carrying one grid request.
interface ugbb_req_if;
    logic                                    valid;
    logic                                    ready;
    logic        [ugbb_pkg::OP_W-1:0]        op;
    logic        [ugbb_pkg::ID_W-1:0]        entity_id;
    logic signed [ugbb_pkg::COORD_W-1:0]     min_x;
    logic signed [ugbb_pkg::COORD_W-1:0]     min_y;
    logic signed [ugbb_pkg::COORD_W-1:0]     max_x;
    logic signed [ugbb_pkg::COORD_W-1:0]     max_y;
    logic        [ugbb_pkg::CIDX_W-1:0]      cell_x;
    logic        [ugbb_pkg::CIDX_W-1:0]      cell_y;

    modport source (
        output valid, op, entity_id, min_x, min_y, max_x, max_y, cell_x, cell_y,
        input  ready
    );
    modport sink (
        input  valid, op, entity_id, min_x, min_y, max_x, max_y, cell_x, cell_y,
        output ready
    );
endinterface

FILE: hdl/ugbb_rsp_if.sv
// Result channel: valid/ready handshake carrying one result of a request.
interface ugbb_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [ugbb_pkg::STATUS_W-1:0]     status;
    logic [ugbb_pkg::ID_W-1:0]         slot_entity;
    logic                              slot_valid;
    logic                              last;

    modport source (
        output valid, status, slot_entity, slot_valid, last,
        input  ready
    );
    modport sink (
        input  valid, status, slot_entity, slot_valid, last,
        output ready
    );
endinterface

FILE: hdl/ugbb_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module ugbb_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/uniform_grid_broadphase_bins.sv
// Top level of the uniform grid broad-phase binning block.
// Use: requests arrive on i_req (valid/ready); results leave on o_rsp, each
// with status, slot_entity, slot_valid and last. Origin registers sit on an
// APB-style port (byte address 0 origin_x, 4 origin_y), always ready.
// Add: four corner-to-cell divisions share one multiplier, each a reciprocal
// multiply, a back multiply and a correction; then a range check, a
// base-address multiply, and for each covered cell a fill read, then a slot
// and fill write. Clear: one sweep over the fill memory, then one result.
// Read: a base multiply, a fill read, then a slot read and an emit for each
// slot through the slot memory port, SLOTS_PER_CELL results (one when the
// cell is out of range). One request is in work at a time; i_req.ready is
// high only while the sequencer idles.
// Reset: the block sweeps the fill memory to empty with i_req.ready low;
// register writes are taken meanwhile.
// Stall: a result sits in the output register until o_rsp.ready; the
// sequencer waits for it, and a new request may enter as soon as the last
// result of the previous one is loaded.
module uniform_grid_broadphase_bins #(
    parameter int GRID_COLS      = ugbb_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS      = ugbb_pkg::GRID_ROWS_DEF,
    parameter int CELL_SIZE      = ugbb_pkg::CELL_SIZE_DEF,
    parameter int SLOTS_PER_CELL = ugbb_pkg::SLOTS_PER_CELL_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ugbb_req_if.sink                      i_req,
    ugbb_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ugbb_pkg::APB_AW-1:0]   paddr,
    input  logic [ugbb_pkg::APB_DW-1:0]   pwdata,
    output logic [ugbb_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int CW_ = ugbb_pkg::COORD_W;
    localparam int NUM_CELLS = GRID_COLS * GRID_ROWS;
    localparam int CW  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int XW  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int YW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int SLW = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
    localparam int FW  = $clog2(SLOTS_PER_CELL + 1);
    localparam int SDEPTH = NUM_CELLS * (2 ** SLW);
    localparam int SAW = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;

    // Floor division by the cell size: offset the difference by CK cells to
    // make it positive, divide by reciprocal multiply, fix by one compare.
    localparam int NW  = CW_ + 2;
    localparam int QW  = NW + 1;
    localparam int RSH = 30;
    localparam int MW  = RSH + 1;
    localparam int PW  = NW + MW;
    localparam int CK  = (65536 + CELL_SIZE - 1) / CELL_SIZE;
    localparam int OFS = CK * CELL_SIZE;
    localparam longint unsigned RECIP = (64'd1 << RSH) / CELL_SIZE;
    localparam logic signed [QW-1:0] CK_Q   = QW'(CK);
    localparam logic signed [QW-1:0] COLS_Q = QW'(GRID_COLS);
    localparam logic signed [QW-1:0] ROWS_Q = QW'(GRID_ROWS);
    localparam logic [CW-1:0]  LAST_CELL = CW'(NUM_CELLS - 1);
    localparam logic [SLW-1:0] LAST_SLOT = SLW'(SLOTS_PER_CELL - 1);

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_DIV1, S_DIV2, S_DIV3, S_CHK, S_BASE, S_WSET,
        S_WRD, S_WWR, S_RBASE, S_RADDR, S_RSRD, S_RSEMIT, S_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic signed [CW_-1:0] r_origin_x;
    logic signed [CW_-1:0] r_origin_y;

    // latched request
    logic        [ugbb_pkg::ID_W-1:0]   r_id;
    logic signed [CW_-1:0]              r_min_x, r_min_y, r_max_x, r_max_y;
    logic        [ugbb_pkg::CIDX_W-1:0] r_cx, r_cy;

    // sequencer working state
    logic [1:0]               r_ci;
    logic signed [QW-1:0]     r_cell [4];
    logic [NW-1:0]            r_q0;
    logic [PW-1:0]            r_prod;
    logic [CW-1:0]            r_addr;
    logic [CW-1:0]            r_colbase;
    logic [XW-1:0]            r_x;
    logic [YW-1:0]            r_y;
    logic [SLW-1:0]           r_k;
    logic                     r_clr_reply;
    logic [ugbb_pkg::STATUS_W-1:0] r_fin_status;

    // output register
    logic                          r_ovalid;
    logic [ugbb_pkg::STATUS_W-1:0] r_ostatus;
    logic [ugbb_pkg::ID_W-1:0]     r_oentity;
    logic                          r_oslot_valid;
    logic                          r_olast;

    // combinational
    logic                   accept;
    logic                   out_free;
    logic                   load_out;
    logic signed [CW_-1:0]  coord_sel;
    logic signed [CW_-1:0]  origin_sel;
    logic signed [NW:0]     diff;
    logic [NW-1:0]          num;
    logic [NW-1:0]          rem;
    logic                   corr;
    logic signed [QW-1:0]   quot;
    logic [NW-1:0]          mul_a;
    logic [MW-1:0]          mul_b;
    logic                   full;
    logic                   fill_we, fill_re;
    logic [CW-1:0]          fill_raddr;
    logic [FW-1:0]          fill_wdata, fill_rdata;
    logic                   slot_we, slot_re;
    logic [SAW-1:0]         slot_waddr, slot_raddr;
    logic [ugbb_pkg::ID_W-1:0] slot_rdata;
    logic                   out_of_grid;
    logic                   inverted;

    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_ovalid || o_rsp.ready;
    assign load_out = out_free && ((r_state == S_RSEMIT) || (r_state == S_FIN));
    assign i_req.ready = (r_state == S_IDLE);

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ugbb_pkg::REG_ORIGIN_Y)
                  ? ugbb_pkg::APB_DW'(r_origin_y) : ugbb_pkg::APB_DW'(r_origin_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= ugbb_pkg::ORIGIN_RESET;
            r_origin_y <= ugbb_pkg::ORIGIN_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == ugbb_pkg::REG_ORIGIN_Y) begin
                r_origin_y <= pwdata[CW_-1:0];
            end else begin
                r_origin_x <= pwdata[CW_-1:0];
            end
        end
    end

    // ---------------- corner to cell divide ----------------
    // Corner order: min_x, min_y, max_x, max_y; odd corners use origin_y.
    always_comb begin
        case (r_ci)
            2'd0:    coord_sel = r_min_x;
            2'd1:    coord_sel = r_min_y;
            2'd2:    coord_sel = r_max_x;
            default: coord_sel = r_max_y;
        endcase
    end
    assign origin_sel = r_ci[0] ? r_origin_y : r_origin_x;
    assign diff = $signed({{(NW+1-CW_){coord_sel[CW_-1]}}, coord_sel})
                - $signed({{(NW+1-CW_){origin_sel[CW_-1]}}, origin_sel})
                + $signed((NW+1)'(OFS));
    assign num  = diff[NW-1:0];
    // r_prod holds q0 * CELL_SIZE in S_DIV3
    assign rem  = num - r_prod[NW-1:0];
    assign corr = (rem >= NW'(CELL_SIZE));
    assign quot = $signed({1'b0, r_q0}) + $signed(QW'(corr)) - CK_Q;

    // ---------------- shared multiplier ----------------
    always_comb begin
        case (r_state)
            S_DIV1: begin
                mul_a = num;
                mul_b = MW'(RECIP);
            end
            S_DIV2: begin
                mul_a = r_prod[RSH +: NW];
                mul_b = MW'(CELL_SIZE);
            end
            S_BASE: begin
                mul_a = NW'(r_cell[0]);
                mul_b = MW'(GRID_ROWS);
            end
            S_RBASE: begin
                mul_a = NW'(r_cx);
                mul_b = MW'(GRID_ROWS);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
    end

    // ---------------- box range checks ----------------
    assign out_of_grid = (r_cell[0] < 0) || (r_cell[1] < 0)
                      || (r_cell[2] >= COLS_Q) || (r_cell[3] >= ROWS_Q);
    assign inverted    = (r_cell[0] > r_cell[2]) || (r_cell[1] > r_cell[3]);

    // ---------------- memory ports ----------------
    assign full       = (fill_rdata >= FW'(SLOTS_PER_CELL));
    assign fill_we    = (r_state == S_SWEEP) || ((r_state == S_WWR) && !full);
    assign fill_wdata = (r_state == S_SWEEP) ? '0 : fill_rdata + FW'(1);
    assign fill_re    = (r_state == S_WRD) || (r_state == S_RADDR);
    assign fill_raddr = (r_state == S_RADDR) ? CW'(r_prod) + CW'(r_cy) : r_addr;
    assign slot_we    = (r_state == S_WWR) && !full;
    assign slot_waddr = SAW'({r_addr, SLW'(fill_rdata)});
    assign slot_re    = (r_state == S_RSRD);
    assign slot_raddr = SAW'({r_addr, r_k});

    ugbb_ram #(.WIDTH(FW), .DEPTH(NUM_CELLS)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (r_addr),
        .i_wdata (fill_wdata),
        .i_re    (fill_re),
        .i_raddr (fill_raddr),
        .o_rdata (fill_rdata)
    );

    ugbb_ram #(.WIDTH(ugbb_pkg::ID_W), .DEPTH(SDEPTH)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (r_id),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    // ---------------- sequencer and output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_addr      <= '0;
            r_clr_reply <= 1'b0;
            r_ovalid    <= 1'b0;
            r_ci        <= '0;
            r_k         <= '0;
        end else begin
            // drop the result once taken unless a new one is loaded below
            if (o_rsp.ready && !load_out) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    if (r_addr == LAST_CELL) begin
                        r_addr <= '0;
                        if (r_clr_reply) begin
                            r_fin_status <= ugbb_pkg::ST_OK;
                            r_state      <= S_FIN;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_addr <= r_addr + CW'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_id    <= i_req.entity_id;
                        r_min_x <= i_req.min_x;
                        r_min_y <= i_req.min_y;
                        r_max_x <= i_req.max_x;
                        r_max_y <= i_req.max_y;
                        r_cx    <= i_req.cell_x;
                        r_cy    <= i_req.cell_y;
                        r_ci    <= '0;
                        r_k     <= '0;
                        case (i_req.op)
                            ugbb_pkg::OP_ADD: begin
                                r_state <= S_DIV1;
                            end
                            ugbb_pkg::OP_CLEAR: begin
                                r_addr      <= '0;
                                r_clr_reply <= 1'b1;
                                r_state     <= S_SWEEP;
                            end
                            ugbb_pkg::OP_READ: begin
                                if ((i_req.cell_x >= GRID_COLS) ||
                                    (i_req.cell_y >= GRID_ROWS)) begin
                                    r_fin_status <= ugbb_pkg::ST_BAD_CELL;
                                    r_state      <= S_FIN;
                                end else begin
                                    r_state <= S_RBASE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV1: begin
                    r_state <= S_DIV2;
                end
                S_DIV2: begin
                    r_q0    <= r_prod[RSH +: NW];
                    r_state <= S_DIV3;
                end
                S_DIV3: begin
                    r_cell[r_ci] <= quot;
                    r_ci         <= r_ci + 2'd1;
                    r_state      <= (r_ci == 2'd3) ? S_CHK : S_DIV1;
                end
                S_CHK: begin
                    if (out_of_grid) begin
                        r_fin_status <= ugbb_pkg::ST_OUTSIDE;
                        r_state      <= S_FIN;
                    end else if (inverted) begin
                        r_fin_status <= ugbb_pkg::ST_OK;
                        r_state      <= S_FIN;
                    end else begin
                        r_state <= S_BASE;
                    end
                end
                S_BASE: begin
                    r_state <= S_WSET;
                end
                S_WSET: begin
                    r_colbase <= CW'(r_prod) + CW'(r_cell[1]);
                    r_addr    <= CW'(r_prod) + CW'(r_cell[1]);
                    r_x       <= XW'(r_cell[0]);
                    r_y       <= YW'(r_cell[1]);
                    r_state   <= S_WRD;
                end
                S_WRD: begin
                    r_state <= S_WWR;
                end
                S_WWR: begin
                    if (full) begin
                        // stop at the first full cell; earlier cells keep the id
                        r_fin_status <= ugbb_pkg::ST_OVERFLOW;
                        r_state      <= S_FIN;
                    end else if (r_y == YW'(r_cell[3])) begin
                        if (r_x == XW'(r_cell[2])) begin
                            r_fin_status <= ugbb_pkg::ST_OK;
                            r_state      <= S_FIN;
                        end else begin
                            r_x       <= r_x + XW'(1);
                            r_y       <= YW'(r_cell[1]);
                            r_colbase <= r_colbase + CW'(GRID_ROWS);
                            r_addr    <= r_colbase + CW'(GRID_ROWS);
                            r_state   <= S_WRD;
                        end
                    end else begin
                        r_y     <= r_y + YW'(1);
                        r_addr  <= r_addr + CW'(1);
                        r_state <= S_WRD;
                    end
                end
                S_RBASE: begin
                    r_state <= S_RADDR;
                end
                S_RADDR: begin
                    r_addr  <= fill_raddr;
                    r_state <= S_RSRD;
                end
                S_RSRD: begin
                    r_state <= S_RSEMIT;
                end
                S_RSEMIT: begin
                    if (out_free) begin
                        r_ovalid      <= 1'b1;
                        r_ostatus     <= ugbb_pkg::ST_OK;
                        r_oslot_valid <= (fill_rdata > FW'(r_k));
                        r_oentity     <= (fill_rdata > FW'(r_k)) ? slot_rdata : '0;
                        r_olast       <= (r_k == LAST_SLOT);
                        if (r_k == LAST_SLOT) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + SLW'(1);
                            r_state <= S_RSRD;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ovalid      <= 1'b1;
                        r_ostatus     <= r_fin_status;
                        r_oentity     <= '0;
                        r_oslot_valid <= 1'b0;
                        r_olast       <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.status      = r_ostatus;
    assign o_rsp.slot_entity = r_oentity;
    assign o_rsp.slot_valid  = r_oslot_valid;
    assign o_rsp.last        = r_olast;

endmodule

FILE: hdl/ugbb_checker.sv
// Port-level assertions for the grid binning block, bound to its top level.
module ugbb_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    ugbb_req_if.sink    req,
    ugbb_rsp_if.source  rsp
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status)
            && $stable(rsp.slot_entity) && $stable(rsp.slot_valid) && $stable(rsp.last))
        else $error("result changed while stalled");

    a_slot_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && rsp.slot_valid |-> rsp.status == ugbb_pkg::ST_OK)
        else $error("filled slot with error status");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && rsp.status != ugbb_pkg::ST_OK |-> rsp.last)
        else $error("error result not marked last");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && !rsp.slot_valid |-> rsp.slot_entity == '0)
        else $error("empty slot carries an id");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !rsp.valid && !req.ready)
        else $error("busy flags not cleared by reset");

endmodule

bind uniform_grid_broadphase_bins ugbb_checker u_ugbb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .req     (i_req),
    .rsp     (o_rsp)
);

FILE: tb/uniform_grid_broadphase_bins_test.sv
// Self-checking testbench for the uniform grid broad-phase binning block.
`timescale 1ns / 1ps

module uniform_grid_broadphase_bins_test;

    localparam int COLS      = ugbb_pkg::GRID_COLS_DEF;
    localparam int ROWS      = ugbb_pkg::GRID_ROWS_DEF;
    localparam int CSIZE     = ugbb_pkg::CELL_SIZE_DEF;
    localparam int SLOTS     = ugbb_pkg::SLOTS_PER_CELL_DEF;
    localparam int NUM_CELLS = COLS * ROWS;

    localparam int OP_W     = ugbb_pkg::OP_W;
    localparam int ID_W     = ugbb_pkg::ID_W;
    localparam int COORD_W  = ugbb_pkg::COORD_W;
    localparam int CIDX_W   = ugbb_pkg::CIDX_W;
    localparam int STATUS_W = ugbb_pkg::STATUS_W;
    localparam int APB_AW   = ugbb_pkg::APB_AW;
    localparam int APB_DW   = ugbb_pkg::APB_DW;

    // op 3 has no function in the block; it must be swallowed without a result
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Quiet cycles tolerated before the run is declared hung. The longest legal
    // quiet stretch is a request covering the whole grid on top of a receiver
    // hold-off, so leave a wide margin over that.
    localparam int QUIET_LIMIT   = 40000;
    // Cycles to let pass after the last result before touching the origin
    // registers or ending the run; covers a request that makes no result.
    localparam int SETTLE_CYCLES = 64;
    // Long receiver hold-off, so the block fills up and blocks new requests.
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [ID_W-1:0]           entity_id;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic [CIDX_W-1:0]         cell_x;
        logic [CIDX_W-1:0]         cell_y;
    } t_grid_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     slot_entity;
        logic                slot_valid;
        logic                last;
    } t_grid_rsp;

    // ------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    t_grid_req req_item  = '0;
    logic      req_valid = 1'b0;
    logic      rsp_ready = 1'b0;

    ugbb_req_if req_bus ();
    ugbb_rsp_if rsp_bus ();

    assign req_bus.valid     = req_valid;
    assign req_bus.op        = req_item.op;
    assign req_bus.entity_id = req_item.entity_id;
    assign req_bus.min_x     = req_item.min_x;
    assign req_bus.min_y     = req_item.min_y;
    assign req_bus.max_x     = req_item.max_x;
    assign req_bus.max_y     = req_item.max_y;
    assign req_bus.cell_x    = req_item.cell_x;
    assign req_bus.cell_y    = req_item.cell_y;
    assign rsp_bus.ready     = rsp_ready;

    uniform_grid_broadphase_bins u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin : clock_gen
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the grid: origin registers, per-cell fill and slot ids
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] origin_x_cfg = ugbb_pkg::ORIGIN_RESET;
    logic signed [COORD_W-1:0] origin_y_cfg = ugbb_pkg::ORIGIN_RESET;
    int unsigned               cell_used [NUM_CELLS];
    logic [ID_W-1:0]           cell_slots [NUM_CELLS][SLOTS];

    t_grid_req requests_pending [$];
    t_grid_rsp results_due [$];

    int n_queued   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_fail     = 0;
    int n_placed   = 0;
    int n_outside  = 0;
    int n_overflow = 0;
    int n_reads    = 0;
    int n_clears   = 0;

    // Per-item idle limits; the stimulus process changes them between phases.
    int gap_max   = 15;
    int stall_max = 15;

    int gap_left     = 0;
    int stall_left   = 0;
    int quiet_cycles = 0;

    // Floor division of the offset from the origin by the cell size.
    function automatic int cell_of(logic signed [COORD_W-1:0] coord,
                                   logic signed [COORD_W-1:0] origin);
        int d;
        int q;
        d = int'(coord) - int'(origin);
        q = d / CSIZE;
        if ((d % CSIZE) != 0 && d < 0) q = q - 1;
        return q;
    endfunction

    // Apply one accepted request to the shadow grid and queue its results.
    task automatic apply_to_grid(input t_grid_req r);
        int sx, sy, ex, ey, x, y, c, k;
        bit stop;
        t_grid_rsp res;
        res  = '0;
        stop = 1'b0;
        case (r.op)
            ugbb_pkg::OP_ADD: begin
                sx = cell_of(r.min_x, origin_x_cfg);
                sy = cell_of(r.min_y, origin_y_cfg);
                ex = cell_of(r.max_x, origin_x_cfg);
                ey = cell_of(r.max_y, origin_y_cfg);
                res.status = ugbb_pkg::ST_OK;
                res.last   = 1'b1;
                if (sx < 0 || sy < 0 || ex >= COLS || ey >= ROWS) begin
                    res.status = ugbb_pkg::ST_OUTSIDE;
                end else begin
                    // walk x outer, y inner; stop at the first full cell and
                    // keep whatever was written before it
                    for (x = sx; x <= ex && !stop; x++) begin
                        for (y = sy; y <= ey && !stop; y++) begin
                            c = x * ROWS + y;
                            if (cell_used[c] >= SLOTS) begin
                                res.status = ugbb_pkg::ST_OVERFLOW;
                                stop = 1'b1;
                            end else begin
                                cell_slots[c][cell_used[c]] = r.entity_id;
                                cell_used[c]++;
                            end
                        end
                    end
                end
                case (res.status)
                    ugbb_pkg::ST_OUTSIDE:  n_outside++;
                    ugbb_pkg::ST_OVERFLOW: n_overflow++;
                    default:               n_placed++;
                endcase
                results_due.push_back(res);
            end
            ugbb_pkg::OP_CLEAR: begin
                for (c = 0; c < NUM_CELLS; c++) cell_used[c] = 0;
                res.status = ugbb_pkg::ST_OK;
                res.last   = 1'b1;
                n_clears++;
                results_due.push_back(res);
            end
            ugbb_pkg::OP_READ: begin
                n_reads++;
                if (r.cell_x >= COLS || r.cell_y >= ROWS) begin
                    res.status = ugbb_pkg::ST_BAD_CELL;
                    res.last   = 1'b1;
                    results_due.push_back(res);
                end else begin
                    c = int'(r.cell_x) * ROWS + int'(r.cell_y);
                    for (k = 0; k < SLOTS; k++) begin
                        res.status      = ugbb_pkg::ST_OK;
                        res.slot_valid  = (k < cell_used[c]);
                        res.slot_entity = res.slot_valid ? cell_slots[c][k] : '0;
                        res.last        = (k == SLOTS - 1);
                        results_due.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Request driver: pop pending requests, hold each until accepted,
    // then idle a random number of cycles before the next one.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : request_drive
        int gap;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
            gap_left  <= 0;
        end else if (req_valid && req_bus.ready) begin
            apply_to_grid(req_item);
            n_accepted++;
            gap = $urandom_range(gap_max, 0);
            if (gap == 0 && requests_pending.size() != 0) begin
                // keep valid high straight into the next request
                req_item  <= requests_pending.pop_front();
                req_valid <= 1'b1;
            end else begin
                req_valid <= 1'b0;
                gap_left  <= gap;
            end
        end else if (!req_valid) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
            end else if (requests_pending.size() != 0) begin
                req_item  <= requests_pending.pop_front();
                req_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest one due,
    // then stall ready for a random count. Twice in the run, hold off for a
    // long stretch so the output register backs up into the request side.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_grid_rsp got;
        t_grid_rsp want;
        int pause;
        if (!i_rst_n) begin
            rsp_ready  <= 1'b0;
            stall_left <= 1;
        end else if (rsp_bus.valid && rsp_ready) begin
            got.status      = rsp_bus.status;
            got.slot_entity = rsp_bus.slot_entity;
            got.slot_valid  = rsp_bus.slot_valid;
            got.last        = rsp_bus.last;
            if (results_due.size() == 0) begin
                if (n_fail < 40)
                    $display("%0t: unexpected result status=%0d entity=%h valid=%b last=%b",
                             $time, got.status, got.slot_entity, got.slot_valid, got.last);
                n_fail++;
            end else begin
                want = results_due.pop_front();
                if (got.status !== want.status || got.slot_entity !== want.slot_entity ||
                    got.slot_valid !== want.slot_valid || got.last !== want.last) begin
                    if (n_fail < 40)
                        $display("%0t: result mismatch: expected status=%0d entity=%h",
                                 $time, want.status, want.slot_entity,
                                 " valid=%b last=%b,", want.slot_valid, want.last,
                                 " got status=%0d entity=%h", got.status, got.slot_entity,
                                 " valid=%b last=%b", got.slot_valid, got.last);
                    n_fail++;
                end
            end
            n_results++;
            pause = $urandom_range(stall_max, 0);
            if (n_results == 60 || n_results == 300) pause = HOLD_CYCLES;
            stall_left <= pause;
            rsp_ready  <= (pause == 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= (stall_left == 1);
        end
    end

    // Abort if nothing moves on either channel for too long.
    always @(posedge i_clk) begin : watchdog
        if ((req_valid && req_bus.ready) || (rsp_bus.valid && rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles < QUIET_LIMIT) begin
            quiet_cycles <= quiet_cycles + 1;
        end else begin
            $display("%0t: no handshake for %0d cycles, %0d results still due",
                     $time, QUIET_LIMIT, results_due.size());
            $display("** uniform_grid_broadphase_bins: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // World coordinate somewhere inside a cell, clamped to the 16-bit range.
    function automatic logic signed [COORD_W-1:0] world_of(int cell_idx,
                                                           logic signed [COORD_W-1:0] origin);
        int w;
        int off;
        off = $urandom_range(CSIZE - 1, 0);
        w   = int'(origin) + cell_idx * CSIZE + off;
        if (w < -32768) w = -32768;
        if (w > 32767) w = 32767;
        return w[COORD_W-1:0];
    endfunction

    // Request with every field random; callers override what matters.
    function automatic t_grid_req random_req(logic [OP_W-1:0] op);
        t_grid_req r;
        r.op        = op;
        r.entity_id = ID_W'($urandom);
        r.min_x     = COORD_W'($urandom);
        r.min_y     = COORD_W'($urandom);
        r.max_x     = COORD_W'($urandom);
        r.max_y     = COORD_W'($urandom);
        r.cell_x    = CIDX_W'($urandom);
        r.cell_y    = CIDX_W'($urandom);
        return r;
    endfunction

    // Add request for the box spanning cells (cx0, cy0) .. (cx1, cy1).
    function automatic t_grid_req box_req(logic [ID_W-1:0] id, int cx0, int cy0,
                                          int cx1, int cy1);
        t_grid_req r;
        r           = random_req(ugbb_pkg::OP_ADD);
        r.entity_id = id;
        r.min_x     = world_of(cx0, origin_x_cfg);
        r.min_y     = world_of(cy0, origin_y_cfg);
        r.max_x     = world_of(cx1, origin_x_cfg);
        r.max_y     = world_of(cy1, origin_y_cfg);
        return r;
    endfunction

    function automatic t_grid_req read_req(int cx, int cy);
        t_grid_req r;
        r        = random_req(ugbb_pkg::OP_READ);
        r.cell_x = CIDX_W'(cx);
        r.cell_y = CIDX_W'(cy);
        return r;
    endfunction

    task automatic post(input t_grid_req r);
        requests_pending.push_back(r);
        n_queued++;
    endtask

    // Block until every request is taken and every result has come back,
    // then let the sequencer settle.
    task automatic wait_idle();
        @(posedge i_clk);
        while (n_accepted != n_queued || results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one origin register, read it back, and update the shadow copy.
    task automatic program_origin(input logic idx, input logic signed [COORD_W-1:0] val);
        logic [APB_DW-1:0] rd;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // register is written at this edge; turn around into a read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[COORD_W-1:0] !== val) begin
            $display("%0t: origin register %0d read back: expected %h, got %h",
                     $time, idx, val, rd[COORD_W-1:0]);
            n_fail++;
        end
        if (idx == ugbb_pkg::REG_ORIGIN_X) origin_x_cfg = val;
        else origin_y_cfg = val;
    endtask

    task automatic set_origin(input logic signed [COORD_W-1:0] ox,
                              input logic signed [COORD_W-1:0] oy);
        program_origin(ugbb_pkg::REG_ORIGIN_X, ox);
        program_origin(ugbb_pkg::REG_ORIGIN_Y, oy);
    endtask

    // Random requests aimed at a small window of cells so that cells fill up
    // and overflow, mixed with reads of that window, rare clears, and noise.
    task automatic queue_random(input int count);
        int done, sel, wx, wy, x0, y0;
        t_grid_req r;
        wx   = $urandom_range(COLS - 3, 0);
        wy   = $urandom_range(ROWS - 3, 0);
        done = 0;
        while (done < count) begin
            sel = $urandom_range(99, 0);
            x0  = wx + $urandom_range(1, 0);
            y0  = wy + $urandom_range(1, 0);
            done++;
            if (sel < 55) begin
                post(box_req(ID_W'($urandom), x0, y0, x0 + $urandom_range(1, 0),
                             y0 + $urandom_range(1, 0)));
            end else if (sel < 77) begin
                post(read_req(wx + $urandom_range(2, 0), wy + $urandom_range(2, 0)));
            end else if (sel < 82) begin
                post(read_req($urandom_range(COLS - 1, 0), $urandom_range(ROWS - 1, 0)));
            end else if (sel < 84) begin
                post(random_req(ugbb_pkg::OP_CLEAR));
            end else if (sel < 90) begin
                // full-range coordinates: nearly always off the grid
                post(random_req(ugbb_pkg::OP_ADD));
            end else if (sel < 93) begin
                // start past end on one axis: covers nothing
                if (sel[0]) post(box_req(ID_W'($urandom), x0 + 1, y0, x0, y0));
                else post(box_req(ID_W'($urandom), x0, y0 + 1, x0, y0));
            end else if (sel < 97) begin
                // one corner just past an edge of the grid
                r = box_req(ID_W'($urandom), x0, y0, x0, y0);
                case ($urandom_range(3, 0))
                    0:       r.min_x = world_of(-1, origin_x_cfg);
                    1:       r.min_y = world_of(-1, origin_y_cfg);
                    2:       r.max_x = world_of(COLS, origin_x_cfg);
                    default: r.max_y = world_of(ROWS, origin_y_cfg);
                endcase
                post(r);
            end else begin
                // ignored by the block; does not count toward the total
                post(random_req(OP_UNUSED));
                done--;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_grid_req r;
        int k;
        int ox, oy;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset origin (grid spans -1024 .. 1023)
        post(box_req(16'hFFFF, 0, 0, 0, 0));                        // lowest cell
        post(box_req(16'h0000, COLS - 1, ROWS - 1, COLS - 1, ROWS - 1)); // highest cell
        post(box_req(16'h1234, -1, 3, 2, 3));                       // left edge outside
        post(box_req(16'h4321, 3, 3, 3, ROWS));                     // top edge outside
        r = random_req(ugbb_pkg::OP_ADD);
        r.min_x = 16'sh8000;
        r.min_y = 16'sh8000;
        r.max_x = 16'sh7FFF;
        r.max_y = 16'sh7FFF;
        post(r);                                                    // whole coordinate span
        post(box_req(16'h5A5A, 9, 2, 7, 4));                        // inverted on x
        for (k = 0; k < SLOTS; k++) post(box_req(ID_W'(16'h1000 + k), 5, 5, 5, 5));
        post(box_req(16'h2000, 4, 5, 5, 5));   // writes (4,5), then hits full (5,5)
        post(read_req(5, 5));
        post(read_req(4, 5));
        post(read_req(0, 0));
        post(read_req(COLS - 1, ROWS - 1));
        post(random_req(OP_UNUSED));
        post(random_req(ugbb_pkg::OP_CLEAR));
        post(read_req(5, 5));
        post(box_req(16'hC3C3, 0, 0, COLS - 1, ROWS - 1));          // every cell once
        post(read_req(COLS - 1, 0));
        wait_idle();

        // Extreme origins: grid pinned at the bottom of x and the top of y
        set_origin(16'sh8000, 16'sh7FFF);
        queue_random(50);
        wait_idle();

        // Swap extremes and run back to back, no idling on either side
        gap_max   = 0;
        stall_max = 0;
        set_origin(16'sh7FFF, 16'sh8000);
        queue_random(40);
        wait_idle();

        // Fully random origin, both sides idling
        gap_max   = 15;
        stall_max = 15;
        set_origin(COORD_W'($urandom), COORD_W'($urandom));
        queue_random(80);
        wait_idle();

        // Origin near the middle, sender idles and receiver always ready
        stall_max = 0;
        ox = $urandom_range(4095, 0);
        oy = $urandom_range(4095, 0);
        set_origin(COORD_W'(ox - 2048), COORD_W'(oy - 2048));
        queue_random(80);
        wait_idle();

        if (results_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, results_due.size());
            n_fail++;
        end

        $display("Ran %0d requests under five origin settings, %0d results checked.",
                 n_accepted, n_results);
        $display("Adds: %0d placed, %0d off grid, %0d hit a full cell; %0d reads, %0d clears.",
                 n_placed, n_outside, n_overflow, n_reads, n_clears);
        if (n_fail == 0) begin
            $display("** uniform_grid_broadphase_bins: PASSED **");
        end else begin
            $display("** uniform_grid_broadphase_bins: FAILED **");
        end
        $finish;
    end

endmodule
